// ----- hdl/assert_macros.svh -----
// assertion macros shared by the row decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, clocked on clk, off during rst
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hdl/hacr_pkg.sv -----
// constants and types for the hi-res artifact colour row decoder
`default_nettype none

package hacr_pkg;

  localparam int ROW_BYTES    = 40;
  localparam int PIX_PER_BYTE = 7;
  localparam int COL_W        = 9;
  localparam int CNT_W        = $clog2(ROW_BYTES);
  localparam int LAST_COL     = PIX_PER_BYTE * ROW_BYTES - 1;
  localparam int SPAN_PAD     = 2;
  localparam int JOB_PIX      = 2 * PIX_PER_BYTE;
  localparam int SEL_W        = $clog2(JOB_PIX);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  typedef logic [COL_W-1:0] col_t;
  typedef logic [2:0] code_t;

  localparam code_t CODE_BLACK  = 3'd0;
  localparam code_t CODE_GREEN  = 3'd1;
  localparam code_t CODE_VIOLET = 3'd2;
  localparam code_t CODE_WHITE  = 3'd3;
  localparam code_t CODE_ORANGE = 3'd4;
  localparam code_t CODE_BLUE   = 3'd5;

  // pixels of one request: up to two bytes, lowest mask bit leftmost
  typedef struct packed {
    col_t                       col;
    code_t [JOB_PIX-1:0]        codes;
    logic  [JOB_PIX-1:0]        mask;
  } job_t;

endpackage

`default_nettype wire

// ----- hdl/hacr_if.sv -----
// handshake channels of the row decoder: row bytes, pixels, palette write
`default_nettype none

interface hacr_row_if import hacr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] row_byte;
  col_t       span_first;
  col_t       span_final;
  modport source (output valid, row_byte, span_first, span_final, input ready);
  modport sink   (input valid, row_byte, span_first, span_final, output ready);
endinterface

interface hacr_pixel_if import hacr_pkg::*; ();
  logic       valid;
  logic       ready;
  col_t       pixel_x;
  logic [7:0] pixel_color;
  logic       run_end;
  modport source (output valid, pixel_x, pixel_color, run_end, input ready);
  modport sink   (input valid, pixel_x, pixel_color, run_end, output ready);
endinterface

interface hacr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/hacr_front.sv -----
// front end: takes row bytes, tracks the span and builds pixel colour jobs
`default_nettype none
`include "assert_macros.svh"

module hacr_front import hacr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  hacr_row_if.sink     row,
  output logic         push,
  output job_t         push_job,
  input  logic         full
);

  typedef struct packed {
    code_t [PIX_PER_BYTE-1:0] codes;
    logic  [PIX_PER_BYTE-1:0] mask;
  } byte_out_t;

  localparam int WIN = 3 * PIX_PER_BYTE;

  logic [CNT_W-1:0] seen;
  col_t             col;
  logic [7:0]       h0;
  logic [7:0]       h1;
  col_t             span_low;
  col_t             span_high;

  logic             acc;
  logic             first;
  logic             last;
  byte_out_t        wa;
  byte_out_t        wb;
  col_t             col_next;
  col_t             low_next;
  col_t             high_next;
  logic [COL_W:0]   fin_pad;

  function automatic byte_out_t window_codes(input logic [7:0] w0, input logic [7:0] w1,
                                             input logic [7:0] w2, input col_t cb,
                                             input col_t lo, input col_t hi);
    logic  [WIN-1:0]  lit;
    code_t [WIN-1:0]  base;
    logic  [WIN-1:0]  ins;
    logic             pal;
    logic  [COL_W:0]  cw;
    code_t            v;
    int               p;
    byte_out_t        r;
    for (int i = 0; i < PIX_PER_BYTE; i++) begin
      lit[i]                  = w0[i];
      lit[i+PIX_PER_BYTE]     = w1[i];
      lit[i+2*PIX_PER_BYTE]   = w2[i];
    end
    base = '0;
    ins  = '0;
    for (int i = PIX_PER_BYTE - 1; i <= 2 * PIX_PER_BYTE; i++) begin
      pal = (i < PIX_PER_BYTE) ? w0[7] : ((i < 2 * PIX_PER_BYTE) ? w1[7] : w2[7]);
      cw  = {1'b0, cb} + (COL_W+1)'(i) - (COL_W+1)'(PIX_PER_BYTE);
      ins[i] = (cw >= {1'b0, lo}) && (cw <= {1'b0, hi});
      if (!lit[i]) begin
        base[i] = CODE_BLACK;
      end else if (lit[i-1] || lit[i+1]) begin
        base[i] = CODE_WHITE;
      end else if (cw[0]) begin
        base[i] = pal ? CODE_ORANGE : CODE_GREEN;
      end else begin
        base[i] = pal ? CODE_BLUE : CODE_VIOLET;
      end
    end
    for (int j = 0; j < PIX_PER_BYTE; j++) begin
      v = base[j+PIX_PER_BYTE];
      p = (cb[0] ^ j[0]) ? j + PIX_PER_BYTE - 1 : j + PIX_PER_BYTE + 1;
      // black pixel borrows the colour of its pair partner
      if (v == CODE_BLACK && ins[p] && base[p] != CODE_BLACK && base[p] != CODE_WHITE) begin
        v = base[p];
      end
      r.codes[j] = v;
      r.mask[j]  = ins[j+PIX_PER_BYTE];
    end
    return r;
  endfunction

  assign row.ready = !full;
  assign acc       = row.valid && row.ready;
  assign first     = (seen == '0);
  assign last      = (seen == CNT_W'(ROW_BYTES - 1));
  assign col_next  = col + COL_W'(PIX_PER_BYTE);

  always_comb begin
    wa = window_codes(h1, h0, row.row_byte, col, span_low, span_high);
    wb = window_codes(h0, row.row_byte, 8'h00, col_next, span_low, span_high);
    push_job.col   = col;
    push_job.codes = {wb.codes, wa.codes};
    push_job.mask  = {(last ? wb.mask : {PIX_PER_BYTE{1'b0}}), wa.mask};
    push           = acc && !first && (push_job.mask != '0);
  end

  always_comb begin
    fin_pad   = {1'b0, row.span_final} + (COL_W+1)'(SPAN_PAD);
    low_next  = (row.span_first >= COL_W'(SPAN_PAD)) ?
                row.span_first - COL_W'(SPAN_PAD) : '0;
    high_next = (fin_pad > (COL_W+1)'(LAST_COL)) ? COL_W'(LAST_COL) : fin_pad[COL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= '0;
      col       <= '0;
      h0        <= '0;
      h1        <= '0;
      span_low  <= '0;
      span_high <= '0;
    end else if (acc) begin
      if (first) begin
        span_low  <= low_next;
        span_high <= high_next;
        h1        <= '0;
        h0        <= row.row_byte;
        col       <= '0;
        seen      <= CNT_W'(1);
      end else begin
        h1   <= h0;
        h0   <= row.row_byte;
        col  <= col_next;
        seen <= last ? '0 : seen + CNT_W'(1);
      end
    end
  end

  `ASSERT_IMPLIES(a_seen_range, 1'b1, seen <= CNT_W'(ROW_BYTES - 1))
  `ASSERT_IMPLIES(a_push_has_room, push, !full)

endmodule

`default_nettype wire

// ----- hdl/hacr_queue.sv -----
// short job queue between front and back end
`default_nettype none
`include "assert_macros.svh"

module hacr_queue import hacr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  `ASSERT_IMPLIES(a_no_underflow, pop, !empty)
  `ASSERT_NEXT(a_push_fills, push && !pop, !empty)

endmodule

`default_nettype wire

// ----- hdl/hacr_back.sv -----
// back end: walks each job's pixel mask and drives the pixel output register
`default_nettype none
`include "assert_macros.svh"

module hacr_back import hacr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  job_t        pop_job,
  input  logic        empty,
  output logic        pop,
  input  logic [7:0]  palette_base,
  hacr_pixel_if.source pixel
);

  logic               cur_valid;
  job_t               cur;
  logic               pix_valid;
  col_t               pix_x;
  logic [7:0]         pix_color;
  logic               pix_end;

  logic               advance;
  logic [SEL_W-1:0]   sel;
  logic [JOB_PIX-1:0] rest;
  logic               done;

  always_comb begin
    sel = '0;
    for (int i = JOB_PIX - 1; i >= 0; i--) begin
      if (cur.mask[i]) begin
        sel = SEL_W'(i);
      end
    end
  end

  assign rest    = cur.mask & (cur.mask - JOB_PIX'(1));
  assign done    = (rest == '0);
  assign advance = cur_valid && (!pix_valid || pixel.ready);
  assign pop     = !empty && (!cur_valid || (advance && done));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur       <= pop_job;
      cur_valid <= 1'b1;
    end else if (advance) begin
      cur.mask <= rest;
      if (done) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (advance) begin
      pix_valid <= 1'b1;
      pix_x     <= cur.col + COL_W'(sel);
      pix_color <= palette_base + 8'(cur.codes[sel]);
      pix_end   <= done;
    end else if (pixel.ready) begin
      pix_valid <= 1'b0;
    end
  end

  assign pixel.valid       = pix_valid;
  assign pixel.pixel_x     = pix_x;
  assign pixel.pixel_color = pix_color;
  assign pixel.run_end     = pix_end;

  `ASSERT_IMPLIES(a_job_not_empty, cur_valid, cur.mask != '0)
  `ASSERT_IMPLIES(a_pixel_in_row, pix_valid, pix_x <= COL_W'(LAST_COL))

endmodule

`default_nettype wire

// ----- hdl/hires_artifact_color_row.sv -----
// top level of the hi-res artifact colour row decoder
// Takes the row bytes of one hi-res display line, one byte per request on row,
// and emits the in-span pixels on pixel one byte late, one pixel per cycle while
// pixel is ready, from the back end's output register; a byte fully inside the
// span gives 7 pixels, the row's last byte up to 14, and bytes or pixels outside
// the span give none. The front end accepts a byte in every cycle while the
// 4-entry job queue has room, so input and output stall independently. The
// palette base written on cfg is added to each colour code at the output and
// must only change while no row data is in flight.
`default_nettype none

module hires_artifact_color_row import hacr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  hacr_row_if.sink      row,
  hacr_pixel_if.source  pixel,
  hacr_cfg_if.sink      cfg
);

  logic [7:0] palette_base;
  logic       push;
  job_t       push_job;
  logic       full;
  logic       pop;
  job_t       pop_job;
  logic       empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_base <= '0;
    end else if (cfg.valid && cfg.ready) begin
      palette_base <= cfg.data;
    end
  end

  hacr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .row      (row),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  hacr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  hacr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_job      (pop_job),
    .empty        (empty),
    .pop          (pop),
    .palette_base (palette_base),
    .pixel        (pixel)
  );

endmodule

`default_nettype wire

// ----- bench/hacr_row_checker.sv -----
// checker for the row decoder: predicts pixels from accepted requests and compares them
`default_nettype none

module hacr_row_checker import hacr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  hacr_row_if   row,
  hacr_pixel_if pixel,
  hacr_cfg_if   cfg,
  output int    errors,
  output int    pending
);

  typedef struct packed {
    col_t       x;
    logic [7:0] color;
    logic       run_end;
  } pixel_t;

  pixel_t     expected_pixels[$];
  pixel_t     byte_pixels[$];
  logic [7:0] base_reg;
  logic [7:0] older_byte;
  logic [7:0] newest_byte;
  int         byte_idx;
  int         span_lo;
  int         span_hi;
  int         err_cnt;

  // in-span pixels of w1, with w0 and w2 as its neighbours
  function automatic void decode_byte(input logic [7:0] w0, input logic [7:0] w1,
                                      input logic [7:0] w2, input int colbase);
    logic [7:0]  win [3];
    logic [20:0] lit;
    code_t       code [21];
    code_t       v;
    code_t       pc;
    int          c;
    int          p;
    int          idx;
    win[0] = w0;
    win[1] = w1;
    win[2] = w2;
    for (int i = 0; i < 21; i++) begin
      lit[i]  = win[i / 7][i % 7];
      code[i] = CODE_BLACK;
    end
    for (int i = 6; i <= 14; i++) begin
      if (lit[i]) begin
        if (lit[i-1] || lit[i+1])
          code[i] = CODE_WHITE;
        else if (((colbase + 1 + i) % 2) != 0)
          code[i] = win[i / 7][7] ? CODE_ORANGE : CODE_GREEN;
        else
          code[i] = win[i / 7][7] ? CODE_BLUE : CODE_VIOLET;
      end
    end
    for (int j = 0; j < 7; j++) begin
      c   = colbase + j;
      idx = 7 + j;
      if (c < span_lo || c > span_hi)
        continue;
      v = code[idx];
      if (v == CODE_BLACK) begin
        p  = c ^ 1;
        pc = (p > c) ? code[idx+1] : code[idx-1];
        if (p >= span_lo && p <= span_hi && pc != CODE_BLACK && pc != CODE_WHITE)
          v = pc;
      end
      byte_pixels.push_back('{x: col_t'(c), color: base_reg + 8'(v), run_end: 1'b0});
    end
  endfunction

  function automatic void take_row_byte(input logic [7:0] b, input col_t f, input col_t l);
    if (byte_idx == 0) begin
      span_lo     = (int'(f) >= SPAN_PAD) ? int'(f) - SPAN_PAD : 0;
      span_hi     = (int'(l) + SPAN_PAD > LAST_COL) ? LAST_COL : int'(l) + SPAN_PAD;
      older_byte  = 8'h00;
      newest_byte = b;
      byte_idx    = 1;
    end else begin
      byte_pixels.delete();
      decode_byte(older_byte, newest_byte, b, PIX_PER_BYTE * (byte_idx - 1));
      older_byte  = newest_byte;
      newest_byte = b;
      if (byte_idx + 1 >= ROW_BYTES) begin
        decode_byte(older_byte, newest_byte, 8'h00, PIX_PER_BYTE * byte_idx);
        byte_idx = 0;
      end else begin
        byte_idx++;
      end
      if (byte_pixels.size() > 0)
        byte_pixels[byte_pixels.size()-1].run_end = 1'b1;
      foreach (byte_pixels[i])
        expected_pixels.push_back(byte_pixels[i]);
    end
  endfunction

  function automatic void check_pixel(input col_t x, input logic [7:0] color,
                                      input logic run_end);
    pixel_t e;
    if (expected_pixels.size() == 0) begin
      $error("unexpected pixel: pixel_x %0d pixel_color %0d run_end %0d", x, color, run_end);
      err_cnt++;
    end else begin
      e = expected_pixels.pop_front();
      if (x !== e.x) begin
        $error("pixel_x: expected %0d, got %0d", e.x, x);
        err_cnt++;
      end
      if (color !== e.color) begin
        $error("pixel_color: expected %0d, got %0d", e.color, color);
        err_cnt++;
      end
      if (run_end !== e.run_end) begin
        $error("run_end: expected %0d, got %0d", e.run_end, run_end);
        err_cnt++;
      end
    end
  endfunction

  initial begin
    err_cnt = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      expected_pixels.delete();
      base_reg    = 8'h00;
      older_byte  = 8'h00;
      newest_byte = 8'h00;
      byte_idx    = 0;
      span_lo     = 0;
      span_hi     = 0;
    end else begin
      if (pixel.valid === 1'b1 && pixel.ready === 1'b1)
        check_pixel(pixel.pixel_x, pixel.pixel_color, pixel.run_end);
      if (row.valid === 1'b1 && row.ready === 1'b1)
        take_row_byte(row.row_byte, row.span_first, row.span_final);
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
        base_reg = cfg.data;
    end
    errors  <= err_cnt;
    pending <= expected_pixels.size();
  end

endmodule

`default_nettype wire

// ----- bench/tb_hires_artifact_color_row.sv -----
// testbench top of the row decoder: row and palette stimulus, random stalls, verdict
`default_nettype none

module tb_hires_artifact_color_row import hacr_pkg::*; ();

  localparam int ITEMS         = 400;
  localparam int RANDOM_ROWS   = ITEMS / ROW_BYTES - 1;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int IDLE_PCT      = 22;

  logic clk = 1'b0;
  logic rst;
  logic calm;
  logic sink_ready = 1'b0;
  int   cycle_count = 0;
  int   fail_count;
  int   pending_count;

  logic [7:0] patterns [$] = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h01, 8'h40, 8'h41, 8'h55,
                               8'hD5, 8'h2A, 8'hAA, 8'h08, 8'h88, 8'h14, 8'h94, 8'h22,
                               8'hA2, 8'h49, 8'hC9, 8'h36, 8'hE3, 8'h1C, 8'h9C, 8'h00};
  logic [7:0] base_settings [$] = '{8'h00, 8'h80, 8'h01, 8'hFA};

  hacr_row_if   row_ch ();
  hacr_pixel_if pix_ch ();
  hacr_cfg_if   cfg_ch ();

  assign pix_ch.ready = sink_ready;

  hires_artifact_color_row dut (
    .clk   (clk),
    .rst   (rst),
    .row   (row_ch),
    .pixel (pix_ch),
    .cfg   (cfg_ch)
  );

  hacr_row_checker chk (
    .clk     (clk),
    .rst     (rst),
    .row     (row_ch),
    .pixel   (pix_ch),
    .cfg     (cfg_ch),
    .errors  (fail_count),
    .pending (pending_count)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    sink_ready  <= calm || ($urandom_range(99) >= IDLE_PCT);
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("hires_artifact_color_row test failed");
      $finish;
    end
  end

  function automatic logic [7:0] random_byte();
    logic [7:0] b;
    case ($urandom_range(4))
      0, 1: b = 8'($urandom);
      2, 3: b = {1'($urandom_range(1)), 7'($urandom & $urandom & $urandom)};
      default: begin
        case ($urandom_range(3))
          0: b = 8'h00;
          1: b = 8'h7F;
          2: b = 8'hFF;
          default: b = 8'h80;
        endcase
      end
    endcase
    return b;
  endfunction

  task automatic pick_span(output col_t f, output col_t l);
    int a;
    int z;
    a = $urandom_range(LAST_COL);
    z = $urandom_range(LAST_COL);
    case ($urandom_range(8))
      0: begin f = 0; l = col_t'(LAST_COL); end
      1: begin f = col_t'(a); l = col_t'(z); end
      2: begin f = col_t'($urandom_range(3)); l = col_t'(z); end
      3: begin f = col_t'(a); l = col_t'($urandom_range(LAST_COL, LAST_COL - 4)); end
      4: begin f = col_t'($urandom_range(LAST_COL, LAST_COL - 2)); l = col_t'(LAST_COL); end
      5: begin f = col_t'(a); l = col_t'(a); end
      6: begin f = col_t'(a); l = col_t'((a >= 4) ? a - $urandom_range(4, 1) : 0); end
      default: begin
        f = col_t'((a < z) ? a : z);
        l = col_t'((a < z) ? z : a);
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input col_t f, input col_t l);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      row_ch.valid <= 1'b0;
      @(posedge clk);
    end
    row_ch.valid      <= 1'b1;
    row_ch.row_byte   <= b;
    row_ch.span_first <= f;
    row_ch.span_final <= l;
    @(posedge clk);
    while (row_ch.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic send_row(input col_t req_first, input col_t req_last, input bit patterned);
    logic [7:0] b;
    for (int k = 0; k < ROW_BYTES; k++) begin
      b = (patterned && k < patterns.size()) ? patterns[k] : random_byte();
      // span fields on later bytes are ignored, so keep them moving
      if (k == 0)
        send_byte(b, req_first, req_last);
      else
        send_byte(b, col_t'($urandom_range(LAST_COL)), col_t'($urandom_range(LAST_COL)));
    end
  endtask

  task automatic wait_drained();
    row_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [7:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    col_t f;
    col_t l;
    rst               <= 1'b1;
    calm              <= 1'b0;
    row_ch.valid      <= 1'b0;
    row_ch.row_byte   <= 8'h00;
    row_ch.span_first <= '0;
    row_ch.span_final <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_base(8'hFF);
    send_row(col_t'(0), col_t'(LAST_COL), 1'b1);

    for (int r = 0; r < RANDOM_ROWS; r++) begin
      if (r % 3 == 0) begin
        wait_drained();
        write_base((r / 3 < base_settings.size()) ? base_settings[r / 3] : 8'($urandom));
      end
      // a stretch with no stalls on either side
      calm <= (r == 4 || r == 5);
      pick_span(f, l);
      send_row(f, l, 1'b0);
    end
    calm <= 1'b0;

    wait_drained();
    if (fail_count == 0 && pending_count == 0)
      $display("hires_artifact_color_row test passed");
    else
      $display("hires_artifact_color_row test failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+hdl
hdl/hacr_pkg.sv
hdl/hacr_if.sv
hdl/hacr_front.sv
hdl/hacr_queue.sv
hdl/hacr_back.sv
hdl/hires_artifact_color_row.sv
bench/hacr_row_checker.sv
bench/tb_hires_artifact_color_row.sv
